FILE: sv/cursor_list_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cursor list engine
// Shorthand for clocked checks, sampled on clk_i with rst_ni as the disable.
// ----------------------------------------------------------------------------
`ifndef CURSOR_LIST_ENGINE_ASSERT_SVH
`define CURSOR_LIST_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cursor_list_engine: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cursor_list_engine: next-cycle check failed");

`endif

FILE: sv/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared constants, codes and control types of the cursor list engine.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int OP_W       = 4;
  localparam int STATUS_W   = 2;
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [OP_W-1:0] {
    OP_PREPEND    = 4'd0,
    OP_APPEND     = 4'd1,
    OP_INS_BEFORE = 4'd2,
    OP_INS_AFTER  = 4'd3,
    OP_DEL_FRONT  = 4'd4,
    OP_DEL_BACK   = 4'd5,
    OP_DEL_CURSOR = 4'd6,
    OP_MV_FRONT   = 4'd7,
    OP_MV_BACK    = 4'd8,
    OP_MV_PREV    = 4'd9,
    OP_MV_NEXT    = 4'd10,
    OP_CLEAR      = 4'd11,
    OP_QUERY      = 4'd12
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_NO_CURSOR = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    EDIT_NONE,
    EDIT_INSERT,
    EDIT_DELETE
  } edit_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_FINISH
  } state_e;

  // Edit broadcast to every cell of the row.
  typedef struct packed {
    edit_e                 kind;
    logic [IDX_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] value;
  } cell_edit_t;

  // List bookkeeping that each cell uses to decide whether it is shown.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             cursor_on;
    logic [IDX_W-1:0] cursor_idx;
  } cell_view_t;

endpackage

FILE: sv/cursor_list_engine.sv
// Flow: an accepted request updates the cell row and list bookkeeping, then the
// group registers of the two-level value gather load, then the result register
// loads once the output is free. No new request is taken until the previous result loads.
// Reset: the list is empty and the cursor undefined; reset clears only control
// state, so the block takes requests as soon as reset is released.
// ----------------------------------------------------------------------------
// cursor_list_engine
// Ordered list of signed values with one cursor, held in a row of shift cells.
// ----------------------------------------------------------------------------
module cursor_list_engine
  import cle_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [OP_W-1:0]              operation_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [STATUS_W-1:0]          status_o,
  output logic [CNT_W-1:0]             item_count_o,
  output logic                         cursor_valid_o,
  output logic [IDX_W-1:0]             cursor_position_o,
  output logic signed [DATA_WIDTH-1:0] front_value_o,
  output logic signed [DATA_WIDTH-1:0] back_value_o,
  output logic signed [DATA_WIDTH-1:0] cursor_value_o
);

  state_e state_d, state_q;

  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic             cur_on_d, cur_on_q;
  logic [IDX_W-1:0] cur_idx_d, cur_idx_q;
  status_e          status_d, status_q;

  logic             out_valid_d, out_valid_q;
  status_e          out_status_q;
  logic [CNT_W-1:0] out_count_q;
  logic             out_cur_on_q;
  logic [IDX_W-1:0] out_cur_idx_q;
  logic [DATA_WIDTH-1:0] out_front_q, out_back_q, out_cursor_q;

  logic accept, out_free, out_load, gather_load;
  logic empty, full, at_head, at_tail;
  logic [CNT_W-1:0] cnt_m1;
  op_e        op;
  cell_edit_t edit, edit_req;
  cell_view_t view;

  logic [DATA_WIDTH-1:0] cell_val  [CAPACITY];
  logic [DATA_WIDTH-1:0] left_val  [CAPACITY];
  logic [DATA_WIDTH-1:0] right_val [CAPACITY];
  logic [DATA_WIDTH-1:0] front_sel [CAPACITY];
  logic [DATA_WIDTH-1:0] back_sel  [CAPACITY];
  logic [DATA_WIDTH-1:0] cur_sel   [CAPACITY];
  logic [DATA_WIDTH-1:0] front_val, back_val, cur_val;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_load    = 1'b0;
    gather_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = S_GATHER;
      end
      S_GATHER: begin
        gather_load = 1'b1;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          in_ready_o = 1'b1;
          state_d    = in_valid_i ? S_GATHER : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Operation decode on list bookkeeping
  // ---------------------------------------------------------------------------
  assign op      = op_e'(operation_i);
  assign cnt_m1  = cnt_q - CNT_W'(1);
  assign empty   = (cnt_q == '0);
  assign full    = (cnt_q >= CNT_W'(CAPACITY));
  assign at_head = (cur_idx_q == '0);
  assign at_tail = ({1'b0, cur_idx_q} == cnt_m1);

  always_comb begin
    status_d       = STS_OK;
    cnt_d          = cnt_q;
    cur_on_d       = cur_on_q;
    cur_idx_d      = cur_idx_q;
    edit_req.kind  = EDIT_NONE;
    edit_req.pos   = '0;
    edit_req.value = DATA_WIDTH'(value_i);
    unique case (op)
      OP_PREPEND: begin
        if (full) begin
          status_d = STS_FULL;
        end else begin
          edit_req.kind = EDIT_INSERT;
          cnt_d         = cnt_q + CNT_W'(1);
          if (cur_on_q) cur_idx_d = cur_idx_q + IDX_W'(1);
        end
      end
      OP_APPEND: begin
        if (full) begin
          status_d = STS_FULL;
        end else begin
          edit_req.kind = EDIT_INSERT;
          edit_req.pos  = cnt_q[IDX_W-1:0];
          cnt_d         = cnt_q + CNT_W'(1);
        end
      end
      OP_INS_BEFORE, OP_INS_AFTER: begin
        priority if (empty) begin
          status_d = STS_EMPTY;
        end else if (!cur_on_q) begin
          status_d = STS_NO_CURSOR;
        end else if (full) begin
          status_d = STS_FULL;
        end else begin
          edit_req.kind = EDIT_INSERT;
          cnt_d         = cnt_q + CNT_W'(1);
          if (op == OP_INS_BEFORE) begin
            edit_req.pos = cur_idx_q;
            cur_idx_d    = cur_idx_q + IDX_W'(1);
          end else begin
            edit_req.pos = cur_idx_q + IDX_W'(1);
          end
        end
      end
      OP_DEL_FRONT: begin
        if (empty) begin
          status_d = STS_EMPTY;
        end else begin
          edit_req.kind = EDIT_DELETE;
          cnt_d         = cnt_m1;
          if (cur_on_q) begin
            if (at_head) begin
              cur_on_d  = 1'b0;
              cur_idx_d = '0;
            end else begin
              cur_idx_d = cur_idx_q - IDX_W'(1);
            end
          end
        end
      end
      OP_DEL_BACK: begin
        if (empty) begin
          status_d = STS_EMPTY;
        end else begin
          edit_req.kind = EDIT_DELETE;
          edit_req.pos  = cnt_m1[IDX_W-1:0];
          cnt_d         = cnt_m1;
          if (cur_on_q && at_tail) begin
            cur_on_d  = 1'b0;
            cur_idx_d = '0;
          end
        end
      end
      OP_DEL_CURSOR: begin
        priority if (empty) begin
          status_d = STS_EMPTY;
        end else if (!cur_on_q) begin
          status_d = STS_NO_CURSOR;
        end else begin
          edit_req.kind = EDIT_DELETE;
          edit_req.pos  = cur_idx_q;
          cnt_d         = cnt_m1;
          cur_on_d      = 1'b0;
          cur_idx_d     = '0;
        end
      end
      OP_MV_FRONT: begin
        if (empty) begin
          status_d = STS_EMPTY;
        end else begin
          cur_on_d  = 1'b1;
          cur_idx_d = '0;
        end
      end
      OP_MV_BACK: begin
        if (empty) begin
          status_d = STS_EMPTY;
        end else begin
          cur_on_d  = 1'b1;
          cur_idx_d = cnt_m1[IDX_W-1:0];
        end
      end
      OP_MV_PREV: begin
        if (empty) begin
          status_d = STS_EMPTY;
        end else if (cur_on_q) begin
          if (at_head) begin
            cur_on_d  = 1'b0;
            cur_idx_d = '0;
          end else begin
            cur_idx_d = cur_idx_q - IDX_W'(1);
          end
        end
      end
      OP_MV_NEXT: begin
        if (empty) begin
          status_d = STS_EMPTY;
        end else if (cur_on_q) begin
          if (at_tail) begin
            cur_on_d  = 1'b0;
            cur_idx_d = '0;
          end else begin
            cur_idx_d = cur_idx_q + IDX_W'(1);
          end
        end
      end
      OP_CLEAR: begin
        cnt_d     = '0;
        cur_on_d  = 1'b0;
        cur_idx_d = '0;
      end
      default: begin
        status_d = STS_OK;
      end
    endcase
  end

  always_comb begin
    edit      = edit_req;
    edit.kind = accept ? edit_req.kind : EDIT_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cur_on_q  <= 1'b0;
      cur_idx_q <= '0;
      status_q  <= STS_OK;
    end else if (accept) begin
      cnt_q     <= cnt_d;
      cur_on_q  <= cur_on_d;
      cur_idx_q <= cur_idx_d;
      status_q  <= status_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------------
  assign view.count      = cnt_q;
  assign view.cursor_on  = cur_on_q;
  assign view.cursor_idx = cur_idx_q;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_val[g] = '0;
    end else begin : g_mid_l
      assign left_val[g] = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_val[g] = '0;
    end else begin : g_mid_r
      assign right_val[g] = cell_val[g+1];
    end

    cle_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .edit_i     (edit),
      .view_i     (view),
      .left_i     (left_val[g]),
      .right_i    (right_val[g]),
      .value_o    (cell_val[g]),
      .front_o    (front_sel[g]),
      .back_o     (back_sel[g]),
      .cursor_o   (cur_sel[g])
    );
  end

  cle_gather u_gather (
    .clk_i    (clk_i),
    .load_i   (gather_load),
    .front_i  (front_sel),
    .back_i   (back_sel),
    .cursor_i (cur_sel),
    .front_o  (front_val),
    .back_o   (back_val),
    .cursor_o (cur_val)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q  <= status_q;
      out_count_q   <= cnt_q;
      out_cur_on_q  <= cur_on_q;
      out_cur_idx_q <= cur_on_q ? cur_idx_q : '0;
      out_front_q   <= front_val;
      out_back_q    <= back_val;
      out_cursor_q  <= cur_val;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign item_count_o      = out_count_q;
  assign cursor_valid_o    = out_cur_on_q;
  assign cursor_position_o = out_cur_idx_q;
  assign front_value_o     = signed'(out_front_q);
  assign back_value_o      = signed'(out_back_q);
  assign cursor_value_o    = signed'(out_cursor_q);

endmodule

FILE: sv/cle_cell.sv
// ----------------------------------------------------------------------------
// cle_cell
// One list position: holds an element and shifts with its neighbors on edits.
// ----------------------------------------------------------------------------
module cle_cell
  import cle_pkg::*;
(
  input  logic                  clk_i,
  input  logic [IDX_W-1:0]      cell_idx_i,
  input  cell_edit_t            edit_i,
  input  cell_view_t            view_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] value_o,
  output logic [DATA_WIDTH-1:0] front_o,
  output logic [DATA_WIDTH-1:0] back_o,
  output logic [DATA_WIDTH-1:0] cursor_o
);

  logic [DATA_WIDTH-1:0] value_d, value_q;
  logic [CNT_W-1:0]      last_idx;
  logic                  is_front, is_back, is_cursor;

  always_comb begin
    value_d = value_q;
    unique case (edit_i.kind)
      EDIT_INSERT: begin
        priority if (cell_idx_i > edit_i.pos) value_d = left_i;
        else if (cell_idx_i == edit_i.pos)    value_d = edit_i.value;
        else                                  value_d = value_q;
      end
      EDIT_DELETE: begin
        if (cell_idx_i >= edit_i.pos) value_d = right_i;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // An empty list gives a last index that no cell matches.
  assign last_idx  = view_i.count - CNT_W'(1);
  assign is_front  = (cell_idx_i == '0) && (view_i.count != '0);
  assign is_back   = ({1'b0, cell_idx_i} == last_idx);
  assign is_cursor = view_i.cursor_on && (cell_idx_i == view_i.cursor_idx);

  assign value_o  = value_q;
  assign front_o  = {DATA_WIDTH{is_front}} & value_q;
  assign back_o   = {DATA_WIDTH{is_back}} & value_q;
  assign cursor_o = {DATA_WIDTH{is_cursor}} & value_q;

endmodule

FILE: sv/cle_gather.sv
// ----------------------------------------------------------------------------
// cle_gather
// Two-level OR tree that collects the front, back and cursor values.
// ----------------------------------------------------------------------------
module cle_gather
  import cle_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  load_i,
  input  logic [DATA_WIDTH-1:0] front_i  [CAPACITY],
  input  logic [DATA_WIDTH-1:0] back_i   [CAPACITY],
  input  logic [DATA_WIDTH-1:0] cursor_i [CAPACITY],
  output logic [DATA_WIDTH-1:0] front_o,
  output logic [DATA_WIDTH-1:0] back_o,
  output logic [DATA_WIDTH-1:0] cursor_o
);

  logic [DATA_WIDTH-1:0] front_grp_d  [NUM_GROUPS];
  logic [DATA_WIDTH-1:0] back_grp_d   [NUM_GROUPS];
  logic [DATA_WIDTH-1:0] cursor_grp_d [NUM_GROUPS];
  logic [DATA_WIDTH-1:0] front_grp_q  [NUM_GROUPS];
  logic [DATA_WIDTH-1:0] back_grp_q   [NUM_GROUPS];
  logic [DATA_WIDTH-1:0] cursor_grp_q [NUM_GROUPS];

  // Each cell's output is already masked, so at most one cell per value is nonzero.
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      front_grp_d[g]  = '0;
      back_grp_d[g]   = '0;
      cursor_grp_d[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < CAPACITY) begin
          front_grp_d[g]  = front_grp_d[g]  | front_i[g * GROUP_SIZE + j];
          back_grp_d[g]   = back_grp_d[g]   | back_i[g * GROUP_SIZE + j];
          cursor_grp_d[g] = cursor_grp_d[g] | cursor_i[g * GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      front_grp_q  <= front_grp_d;
      back_grp_q   <= back_grp_d;
      cursor_grp_q <= cursor_grp_d;
    end
  end

  always_comb begin
    front_o  = '0;
    back_o   = '0;
    cursor_o = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      front_o  = front_o  | front_grp_q[g];
      back_o   = back_o   | back_grp_q[g];
      cursor_o = cursor_o | cursor_grp_q[g];
    end
  end

endmodule

FILE: sv/cle_checker.sv
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks of the cursor list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "cursor_list_engine_assert.svh"

module cle_checker
  import cle_pkg::*;
(
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [STATUS_W-1:0]          status_o,
  input logic [CNT_W-1:0]             item_count_o,
  input logic                         cursor_valid_o,
  input logic [IDX_W-1:0]             cursor_position_o,
  input logic signed [DATA_WIDTH-1:0] front_value_o,
  input logic signed [DATA_WIDTH-1:0] back_value_o,
  input logic signed [DATA_WIDTH-1:0] cursor_value_o
);

  // A waiting result keeps its status, count, front value and cursor value.
  `CLE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(item_count_o) && $stable(front_value_o) && $stable(cursor_value_o))

  // An undefined cursor reports position and value as zero.
  `CLE_ASSERT_NOW(a_cursor_off_zero, out_valid_o && !cursor_valid_o, cursor_position_o == '0 && cursor_value_o == '0)

  // An empty list shows zero end values and no cursor.
  `CLE_ASSERT_NOW(a_empty_view, out_valid_o && item_count_o == '0, front_value_o == '0 && back_value_o == '0 && !cursor_valid_o)

  // A full report leaves the list at capacity, an empty report at zero.
  `CLE_ASSERT_NOW(a_full_status, out_valid_o && status_o == STS_FULL, item_count_o == CNT_W'(CAPACITY))
  `CLE_ASSERT_NOW(a_empty_status, out_valid_o && status_o == STS_EMPTY, item_count_o == '0)

endmodule

bind cursor_list_engine cle_checker u_cle_checker (.*);
